// ----- hw/rtl/gksc_pkg.sv -----
// Package for the gap-keeping speed controller.
// Holds the mode codes, register indexes and fixed controller constants.
// No dependencies.
`default_nettype none

package gksc_pkg;

   // Controller mode as shown on the result channel
   typedef enum logic [2:0] {
      MODE_OFF    = 3'd0,
      MODE_CRUISE = 3'd1,
      MODE_FOLLOW = 3'd2,
      MODE_STOP   = 3'd3,
      MODE_FAULT  = 3'd4
   } mode_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_EMERGENCY_GAP = 3'd0,
      REG_TARGET_GAP    = 3'd1,
      REG_GAP_TOLERANCE = 3'd2,
      REG_CLEAR_ROAD    = 3'd3,
      REG_CRUISE_DRIVE  = 3'd4,
      REG_CLOSE_DRIVE   = 3'd5,
      REG_MIN_MOVING    = 3'd6,
      REG_GAP_GAIN      = 3'd7
   } reg_index_type;

   // Fixed drive limits and fault threshold
   localparam logic [7:0] MAX_DRIVE   = 8'd255;
   localparam logic [7:0] DRIVE_STEP  = 8'd8;
   localparam logic [7:0] FAULT_COUNT = 8'd5;

   // Register reset values
   localparam logic [11:0] RST_EMERGENCY_GAP = 12'd30;
   localparam logic [11:0] RST_TARGET_GAP    = 12'd80;
   localparam logic [11:0] RST_GAP_TOLERANCE = 12'd20;
   localparam logic [11:0] RST_CLEAR_ROAD    = 12'd200;
   localparam logic [7:0]  RST_CRUISE_DRIVE  = 8'd180;
   localparam logic [7:0]  RST_CLOSE_DRIVE   = 8'd90;
   localparam logic [7:0]  RST_MIN_MOVING    = 8'd110;
   localparam logic [15:0] RST_GAP_GAIN      = 16'd256;

endpackage

`default_nettype wire

// ----- hw/rtl/gap_keeping_speed_controller_unit.sv -----
// Gap-keeping speed controller: adaptive cruise control with a slew-limited drive.
// Depends on gksc_pkg (mode codes, register indexes, drive constants).
//
// Usage:
//   req_*  : one distance reading per transfer (run request, valid flag, distance).
//   rsp_*  : one result per reading (mode, drive request, brake, echoes).
//   csr_*  : register writes (index 0..7, data); always ready, user writes only
//            when idle (the block itself does not enforce this).
// A reading is evaluated in the input register, then shown from the result register.
// Throughput: one reading per cycle unless stalled; the limit is the state
// loop through the invalid counter and the last drive value, updated once per reading.
// Stall: when rsp_ready is low the result register holds; the input register
// takes one more reading if empty, then req_ready drops until the result drains.
// Reset: clears both pipeline valid bits, the invalid counter and the last drive
// value, and loads the registers with their default values.
`default_nettype none

module gap_keeping_speed_controller_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // reading channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_run_request,
   input  wire logic        req_sensor_valid,
   input  wire logic [11:0] req_distance_cm,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_mode,
   output logic [7:0]       rsp_drive_request,
   output logic             rsp_brake,
   output logic             rsp_valid_echo,
   output logic [11:0]      rsp_distance_echo,
   // register write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   // Configuration registers
   logic [11:0] emergency_gap_ff;
   logic [11:0] target_gap_ff;
   logic [11:0] gap_tolerance_ff;
   logic [11:0] clear_road_ff;
   logic [7:0]  cruise_drive_ff;
   logic [7:0]  close_drive_ff;
   logic [7:0]  min_moving_ff;
   logic [15:0] gap_gain_ff;

   // Input register
   logic        in_valid_ff;
   logic        in_run_ff;
   logic        in_sensor_ff;
   logic [11:0] in_dist_ff;

   // Controller state
   logic [7:0]  inv_count_ff;
   logic [7:0]  inv_count_in;
   logic [7:0]  last_drive_ff;
   logic [7:0]  last_drive_in;

   // Result register
   logic        out_valid_ff;
   gksc_pkg::mode_type out_mode_ff;
   gksc_pkg::mode_type out_mode_in;
   logic [7:0]  out_drive_ff;
   logic [7:0]  out_drive_in;
   logic        out_brake_ff;
   logic        out_brake_in;
   logic        out_vecho_ff;
   logic [11:0] out_decho_ff;

   // Handshake control
   logic out_load;
   logic in_load;

   // Datapath
   logic               is_emergency;
   logic               in_band;
   logic               below_clear;
   logic               is_follow;
   logic [12:0]        band_top;
   logic signed [12:0] gap_err;
   logic signed [29:0] gain_prod;
   logic signed [30:0] follow_sum;
   logic               round_up;
   logic signed [22:0] follow_quot;
   logic [7:0]         low_bound;
   logic [7:0]         follow_tgt;
   logic [7:0]         drive_tgt;
   logic [7:0]         ramp_tgt;
   logic [9:0]         last_plus;
   logic [9:0]         tgt_plus;
   logic [7:0]         ramp_drive;
   logic [7:0]         inv_count_inc;

   // Pipeline flow: result drains or is empty, input moves when result can load
   assign out_load  = !out_valid_ff || rsp_ready;
   assign in_load   = !in_valid_ff || out_load;
   assign req_ready = in_load;
   assign csr_ready = 1'b1;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         emergency_gap_ff <= gksc_pkg::RST_EMERGENCY_GAP;
         target_gap_ff    <= gksc_pkg::RST_TARGET_GAP;
         gap_tolerance_ff <= gksc_pkg::RST_GAP_TOLERANCE;
         clear_road_ff    <= gksc_pkg::RST_CLEAR_ROAD;
         cruise_drive_ff  <= gksc_pkg::RST_CRUISE_DRIVE;
         close_drive_ff   <= gksc_pkg::RST_CLOSE_DRIVE;
         min_moving_ff    <= gksc_pkg::RST_MIN_MOVING;
         gap_gain_ff      <= gksc_pkg::RST_GAP_GAIN;
      end else if (csr_valid && csr_ready) begin
         unique case (gksc_pkg::reg_index_type'(csr_index))
            gksc_pkg::REG_EMERGENCY_GAP: emergency_gap_ff <= csr_data[11:0];
            gksc_pkg::REG_TARGET_GAP:    target_gap_ff    <= csr_data[11:0];
            gksc_pkg::REG_GAP_TOLERANCE: gap_tolerance_ff <= csr_data[11:0];
            gksc_pkg::REG_CLEAR_ROAD:    clear_road_ff    <= csr_data[11:0];
            gksc_pkg::REG_CRUISE_DRIVE:  cruise_drive_ff  <= csr_data[7:0];
            gksc_pkg::REG_CLOSE_DRIVE:   close_drive_ff   <= csr_data[7:0];
            gksc_pkg::REG_MIN_MOVING:    min_moving_ff    <= csr_data[7:0];
            gksc_pkg::REG_GAP_GAIN:      gap_gain_ff      <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Capture the reading on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_run_ff    <= req_run_request;
         in_sensor_ff <= req_sensor_valid;
         in_dist_ff   <= req_distance_cm;
      end
   end

   // Distance thresholds, tested in priority order
   assign band_top     = {1'b0, target_gap_ff} + {1'b0, gap_tolerance_ff};
   assign is_emergency = in_dist_ff <= emergency_gap_ff;
   assign in_band      = {1'b0, in_dist_ff} <= band_top;
   assign below_clear  = in_dist_ff < clear_road_ff;
   assign is_follow    = in_band || below_clear;
   assign low_bound    = in_band ? close_drive_ff : min_moving_ff;

   // Proportional follow target: (cruise*256 + gain*error) / 256, toward zero
   assign gap_err     = $signed({1'b0, in_dist_ff}) - $signed({1'b0, target_gap_ff});
   assign gain_prod   = 30'($signed({1'b0, gap_gain_ff})) * 30'(gap_err);
   assign follow_sum  = 31'(gain_prod) + $signed({15'd0, cruise_drive_ff, 8'd0});
   assign round_up    = follow_sum[30] && (follow_sum[7:0] != 8'd0);
   assign follow_quot = $signed(follow_sum[30:8]) + $signed({22'd0, round_up});

   // Clamp low bound first, then the cruise drive as upper bound
   always_comb begin
      if (follow_quot < $signed({15'd0, low_bound})) begin
         follow_tgt = low_bound;
      end else if (follow_quot > $signed({15'd0, cruise_drive_ff})) begin
         follow_tgt = cruise_drive_ff;
      end else begin
         follow_tgt = follow_quot[7:0];
      end
   end

   // Slew-limit the drive toward the target
   assign drive_tgt = is_follow ? follow_tgt : cruise_drive_ff;
   assign ramp_tgt  = (drive_tgt > gksc_pkg::MAX_DRIVE) ? gksc_pkg::MAX_DRIVE : drive_tgt;
   assign last_plus = {2'b00, last_drive_ff} + {2'b00, gksc_pkg::DRIVE_STEP};
   assign tgt_plus  = {2'b00, ramp_tgt} + {2'b00, gksc_pkg::DRIVE_STEP};

   always_comb begin
      if ({2'b00, ramp_tgt} > last_plus) begin
         ramp_drive = last_drive_ff + gksc_pkg::DRIVE_STEP;
      end else if (tgt_plus < {2'b00, last_drive_ff}) begin
         ramp_drive = last_drive_ff - gksc_pkg::DRIVE_STEP;
      end else begin
         ramp_drive = ramp_tgt;
      end
   end

   assign inv_count_inc = (inv_count_ff == 8'hFF) ? inv_count_ff : inv_count_ff + 8'd1;

   // Mode decision and next state
   always_comb begin
      inv_count_in  = inv_count_ff;
      last_drive_in = last_drive_ff;
      out_mode_in   = gksc_pkg::MODE_OFF;
      out_drive_in  = 8'd0;
      out_brake_in  = 1'b0;
      if (!in_run_ff) begin
         inv_count_in  = 8'd0;
         last_drive_in = 8'd0;
      end else if (!in_sensor_ff) begin
         inv_count_in  = inv_count_inc;
         last_drive_in = 8'd0;
         out_mode_in   = (inv_count_inc >= gksc_pkg::FAULT_COUNT) ?
                         gksc_pkg::MODE_FAULT : gksc_pkg::MODE_STOP;
      end else begin
         inv_count_in = 8'd0;
         if (is_emergency) begin
            out_mode_in  = gksc_pkg::MODE_STOP;
            out_brake_in = 1'b1;
         end else begin
            out_mode_in   = is_follow ? gksc_pkg::MODE_FOLLOW : gksc_pkg::MODE_CRUISE;
            last_drive_in = ramp_drive;
            out_drive_in  = ramp_drive;
         end
      end
   end

   // Advance state and result when the reading moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         inv_count_ff  <= 8'd0;
         last_drive_ff <= 8'd0;
      end else if (out_load) begin
         out_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            inv_count_ff  <= inv_count_in;
            last_drive_ff <= last_drive_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && in_valid_ff) begin
         out_mode_ff  <= out_mode_in;
         out_drive_ff <= out_drive_in;
         out_brake_ff <= out_brake_in;
         out_vecho_ff <= in_sensor_ff;
         out_decho_ff <= in_dist_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_mode          = out_mode_ff;
   assign rsp_drive_request = out_drive_ff;
   assign rsp_brake         = out_brake_ff;
   assign rsp_valid_echo    = out_vecho_ff;
   assign rsp_distance_echo = out_decho_ff;

   // Braking never comes with a drive request
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_brake) |-> (rsp_drive_request == 8'd0))
      else $error("brake asserted with nonzero drive");

   // An invalid reading zeroes the drive and forgets the last drive value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_echo) |-> (rsp_drive_request == 8'd0 && !rsp_brake))
      else $error("invalid reading produced drive or brake");

   // Off mode leaves the controller fully cleared
   assert property (@(posedge clock) disable iff (reset)
      (out_load && in_valid_ff && !in_run_ff) |=>
         (inv_count_ff == 8'd0 && last_drive_ff == 8'd0))
      else $error("state not cleared after off");

   // Drive moves by at most one step per reading
   assert property (@(posedge clock) disable iff (reset)
      (out_load && in_valid_ff && in_run_ff && in_sensor_ff && !is_emergency) |->
         ({2'b00, out_drive_in} <= last_plus && tgt_plus >= {2'b00, ramp_tgt}
          && ({2'b00, out_drive_in} + {2'b00, gksc_pkg::DRIVE_STEP})
             >= {2'b00, last_drive_ff}))
      else $error("drive slew exceeded");

   // A fault result is only shown after the invalid counter reaches the threshold
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mode == gksc_pkg::MODE_FAULT) |->
         (inv_count_ff >= gksc_pkg::FAULT_COUNT))
      else $error("fault without enough invalid readings");

endmodule

`default_nettype wire
